// ===== sv/nip_pkg.sv =====
// Package for the nested interrupt priority arbiter.
// Holds sizes, codes, payload structs and the vector helpers.
// No dependencies; every other file imports it.
package nip_pkg;

  localparam int NUM_SOURCES = 12;
  localparam int MAX_NEST    = 4;

  localparam int LEVEL_W    = 2;
  localparam int NUM_LEVELS = 1 << LEVEL_W;
  localparam int POS_W      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int NEST_W     = $clog2(MAX_NEST + 1);
  localparam int STK_IDX_W  = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  localparam int SRC_W   = 12;
  localparam int PRIO_W  = 24;
  localparam int PC_W    = 16;
  localparam int HADDR_W = 7;
  localparam int DEPTH_W = 3;
  localparam int CYC_W   = 3;

  localparam int VECTOR_STRIDE = 8;
  localparam int VECTOR_OFFSET = 3;
  localparam logic [CYC_W-1:0] ENTRY_CYCLES = CYC_W'(6);

  typedef enum logic {
    REQ_EVAL   = 1'b0,
    REQ_RETURN = 1'b1
  } req_kind_t;

  // Odd table positions from 3 upwards clear their own request on entry
  function automatic logic [SRC_W-1:0] auto_clear_bits();
    logic [SRC_W-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_SOURCES && i < SRC_W; i++) begin
      m[i] = ((i & 1) != 0) && (i >= 3);
    end
    return m;
  endfunction

  localparam logic [SRC_W-1:0] AUTO_CLEAR_MASK = auto_clear_bits();

  // Vector = interrupt number * 8 + 3; number = pos/2, plus 8 for odd positions
  function automatic logic [HADDR_W-1:0] handler_addr(input logic [POS_W-1:0] pos);
    int n;
    n = int'(pos >> 1) + (pos[0] ? 8 : 0);
    return HADDR_W'(n * VECTOR_STRIDE + VECTOR_OFFSET);
  endfunction

  typedef struct packed {
    logic               found;
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   pos;
  } pick_t;

  typedef struct packed {
    logic              req_type;
    logic              global_enable;
    logic [SRC_W-1:0]  source_enable;
    logic [SRC_W-1:0]  source_request;
    logic [PRIO_W-1:0] source_priority;
    logic [PC_W-1:0]   current_pc;
  } item_t;

  typedef struct packed {
    logic               taken;
    logic [HADDR_W-1:0] handler_address;
    logic [LEVEL_W-1:0] taken_level;
    logic [PC_W-1:0]    return_address;
    logic [SRC_W-1:0]   clear_mask;
    logic [DEPTH_W-1:0] nest_depth;
    logic [CYC_W-1:0]   entry_cycles;
    logic               return_error;
  } result_t;

endpackage

// ===== sv/nip_in_if.sv =====
// Input channel of the nested interrupt priority arbiter.
// Valid/ready handshake with the item fields; depends on nip_pkg.
interface nip_in_if
  import nip_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic              global_enable;
  logic [SRC_W-1:0]  source_enable;
  logic [SRC_W-1:0]  source_request;
  logic [PRIO_W-1:0] source_priority;
  logic [PC_W-1:0]   current_pc;

  modport source (
    output valid, req_type, global_enable, source_enable, source_request,
           source_priority, current_pc,
    input  ready
  );

  modport sink (
    input  valid, req_type, global_enable, source_enable, source_request,
           source_priority, current_pc,
    output ready
  );
endinterface

// ===== sv/nip_out_if.sv =====
// Result channel of the nested interrupt priority arbiter.
// Valid/ready handshake with the result fields; depends on nip_pkg.
interface nip_out_if
  import nip_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               taken;
  logic [HADDR_W-1:0] handler_address;
  logic [LEVEL_W-1:0] taken_level;
  logic [PC_W-1:0]    return_address;
  logic [SRC_W-1:0]   clear_mask;
  logic [DEPTH_W-1:0] nest_depth;
  logic [CYC_W-1:0]   entry_cycles;
  logic               return_error;

  modport source (
    output valid, taken, handler_address, taken_level, return_address,
           clear_mask, nest_depth, entry_cycles, return_error,
    input  ready
  );

  modport sink (
    input  valid, taken, handler_address, taken_level, return_address,
           clear_mask, nest_depth, entry_cycles, return_error,
    output ready
  );
endinterface

// ===== sv/nip_select.sv =====
// Priority picker: highest level among enabled requesting sources,
// lowest table position on a tie. Depends on nip_pkg.
module nip_select
  import nip_pkg::*;
(
  input  logic [SRC_W-1:0]  source_enable,
  input  logic [SRC_W-1:0]  source_request,
  input  logic [PRIO_W-1:0] source_priority,
  output pick_t             pick
);

  logic [NUM_SOURCES-1:0] active;
  logic [NUM_SOURCES-1:0] match [NUM_LEVELS];
  logic [NUM_SOURCES-1:0] sel;

  assign active = source_enable[NUM_SOURCES-1:0] & source_request[NUM_SOURCES-1:0];

  // One match vector per level, built in parallel
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        match[l][i] = active[i] &&
                      (source_priority[LEVEL_W*i +: LEVEL_W] == LEVEL_W'(l));
      end
    end
  end

  always_comb begin
    pick.found = 1'b0;
    pick.level = '0;
    pick.pos   = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (|match[l]) begin
        pick.found = 1'b1;
        pick.level = LEVEL_W'(l);
      end
    end
    sel = match[pick.level];
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (sel[i]) begin
        pick.pos = POS_W'(i);
      end
    end
  end

endmodule

// ===== sv/nip_nest_ctrl.sv =====
// Nesting stack and entry decision. Holds the level stack and depth count,
// forms the result of the item in the input register. Depends on nip_pkg.
module nip_nest_ctrl
  import nip_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    commit,
  input  item_t   item,
  input  pick_t   pick,
  output result_t res
);

  logic [LEVEL_W-1:0]   stack_r [MAX_NEST];
  logic [NEST_W-1:0]    count_r;
  logic [NEST_W-1:0]    count_nxt;
  logic [STK_IDX_W-1:0] top_idx;
  logic [STK_IDX_W-1:0] push_idx;
  logic [LEVEL_W-1:0]   top_lvl;
  logic                 is_return;
  logic                 can_enter;
  logic                 take;
  logic                 pop;
  logic                 err;

  assign is_return = (item.req_type == REQ_RETURN);
  assign top_idx   = STK_IDX_W'(count_r - NEST_W'(1));
  assign push_idx  = STK_IDX_W'(count_r);
  assign top_lvl   = stack_r[top_idx];

  // Enter only above the running handler's level and while there is room
  assign can_enter = pick.found && (count_r < NEST_W'(MAX_NEST)) &&
                     ((count_r == '0) || (pick.level > top_lvl));
  assign take = !is_return && item.global_enable && can_enter;
  assign pop  = is_return && (count_r != '0);
  assign err  = is_return && (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (take) begin
      count_nxt = count_r + NEST_W'(1);
    end else if (pop) begin
      count_nxt = count_r - NEST_W'(1);
    end
  end

  always_comb begin
    res                 = '0;
    res.taken           = take;
    res.nest_depth      = DEPTH_W'(count_nxt);
    res.return_error    = err;
    if (take) begin
      res.handler_address = handler_addr(pick.pos);
      res.taken_level     = pick.level;
      res.return_address  = item.current_pc;
      res.clear_mask      = AUTO_CLEAR_MASK & (SRC_W'(1) << pick.pos);
      res.entry_cycles    = ENTRY_CYCLES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < MAX_NEST; i++) begin
        stack_r[i] <= '0;
      end
    end else if (commit) begin
      count_r <= count_nxt;
      if (take) begin
        stack_r[push_idx] <= pick.level;
      end
    end
  end

endmodule

// ===== sv/nested_interrupt_priority_arbiter_core.sv =====
// Top level of the nested interrupt priority arbiter.
// Input register, picker, nesting control and result register;
// depends on nip_pkg, nip_in_if, nip_out_if, nip_select, nip_nest_ctrl.
//
//   Channel   Direction  Handshake      Carries
//   in_ch     sink       valid/ready    evaluate or return item, request state, pc
//   out_ch    source     valid/ready    one result item per input item
//
// Each item passes through the input register and then the result
// register, one item per cycle sustained while the result is not stalled.
// The nesting stack and depth count change in the cycle the item moves into
// the result register, so items take effect strictly in arrival order.
// Synchronous active-low reset empties both registers and the nesting stack.
// A stalled result holds; the input register still fills behind it, and the
// input channel stalls only when both registers are occupied.
module nested_interrupt_priority_arbiter_core
  import nip_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  nip_in_if.sink   in_ch,
  nip_out_if.source out_ch
);

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_r;
  logic    in_accept;
  logic    out_free;
  logic    s1_adv;
  pick_t   pick;
  result_t res;

  // Result register frees when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_accept = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the item on acceptance
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.req_type        <= in_ch.req_type;
      s1_item_r.global_enable   <= in_ch.global_enable;
      s1_item_r.source_enable   <= in_ch.source_enable;
      s1_item_r.source_request  <= in_ch.source_request;
      s1_item_r.source_priority <= in_ch.source_priority;
      s1_item_r.current_pc      <= in_ch.current_pc;
    end
  end

  nip_select u_select (
    .source_enable   (s1_item_r.source_enable),
    .source_request  (s1_item_r.source_request),
    .source_priority (s1_item_r.source_priority),
    .pick            (pick)
  );

  // Commit stack changes only as the item moves into the result register
  nip_nest_ctrl u_nest_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_adv),
    .item   (s1_item_r),
    .pick   (pick),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.taken           = out_r.taken;
  assign out_ch.handler_address = out_r.handler_address;
  assign out_ch.taken_level     = out_r.taken_level;
  assign out_ch.return_address  = out_r.return_address;
  assign out_ch.clear_mask      = out_r.clear_mask;
  assign out_ch.nest_depth      = out_r.nest_depth;
  assign out_ch.entry_cycles    = out_r.entry_cycles;
  assign out_ch.return_error    = out_r.return_error;

`ifndef SYNTHESIS
  // An entry always leaves at least one handler running and charges the entry cost
  a_taken_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.taken) |->
      (out_r.nest_depth != '0) && (out_r.entry_cycles == ENTRY_CYCLES))
    else $error("entry without nesting depth or entry cost");

  // A failed return only happens with nothing running and never enters
  a_return_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.return_error) |->
      (!out_r.taken && (out_r.nest_depth == '0)))
    else $error("return error with handlers in progress");

  // An item leaving the input register must appear as a result next cycle
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item lost before the result register");

  // Depth never exceeds the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.nest_depth <= DEPTH_W'(MAX_NEST)))
    else $error("nesting depth beyond stack size");
`endif

endmodule
